// File: design/stereo_fuzz_wah_effect_unit_defines.svh
// ------------------------------------------------------------------
// Assertion macros for the stereo fuzz and wah effect unit
// Each check is compiled out when NO_ASSERTIONS is defined.
// ------------------------------------------------------------------
`ifndef STEREO_FUZZ_WAH_EFFECT_UNIT_DEFINES_SVH
`define STEREO_FUZZ_WAH_EFFECT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SFW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencing check failed");
`define SFW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("datapath range check failed");
`else
`define SFW_ASSERT_NEXT(lbl, ante, cons)
`define SFW_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

// File: design/sfw_pkg.sv
// ------------------------------------------------------------------
// Shared definitions for the stereo fuzz and wah effect unit
// Constants, register index codes and the sine table generator.
// ------------------------------------------------------------------
`default_nettype none

package sfw_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int LFO_PHASE_BITS   = 24;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam longint unsigned PI_Q30 = 64'd3373259369;
    localparam int DEPTH_Q16        = 19661;
    localparam int GAIN_Q16         = 249037;
    localparam int ONE_Q16          = 65536;
    localparam int FUZZ_TOP         = 32000;
    localparam int FUZZ_STEP_UNIT   = 1000;
    localparam int OUT_MAX          = 32767;
    localparam int FUZZ_SCALE_RESET = 1;
    localparam int LFO_STEP_RESET   = 152;

    localparam logic [CFG_INDEX_W-1:0] REG_FUZZ_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAH_ENABLE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FUZZ_SCALE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAH_CENTER_FREQ = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAH_BANDWIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_PHASE_STEP  = 3'd5;

    // Sine of a first-quadrant entry k of a table of depth d, in Q16.
    function automatic logic [16:0] sine_q16(input int unsigned k, input int unsigned d);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        int unsigned     n;
        x = (PI_Q30 * 64'd2 * 64'(k)) >> $clog2(d);
        term = x;
        sum = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) + 64'd8192) >> 14;
        if (r > 64'd65536)
            r = 64'd65536;
        return r[16:0];
    endfunction

endpackage

`default_nettype wire

// File: design/sfw_sine_rom.sv
// ------------------------------------------------------------------
// Sine table with registered read
// Quarter-wave constant table folded to a full period, Q16 output.
// ------------------------------------------------------------------
`default_nettype none

module sfw_sine_rom #(
    parameter int DEPTH = sfw_pkg::SINE_TABLE_DEPTH
) (
    input  wire                      clk,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    output logic signed [17:0]       sine_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int QW = AW - 1;
    localparam int QN = DEPTH / 4 + 1;

    logic [16:0]        qtab [QN];
    logic               neg;
    logic [QW-1:0]      half;
    logic [QW-1:0]      q;
    logic signed [17:0] mag;
    logic signed [17:0] sine_value_reg;

    for (genvar g = 0; g < QN; g++)
    begin : gen_tab
        localparam logic [16:0] V = sfw_pkg::sine_q16(g, DEPTH);
        assign qtab[g] = V;
    end

    always_comb
    begin
        neg  = addr[AW-1];
        half = addr[AW-2:0];
        if (half > QW'(DEPTH / 4))
            q = QW'(AW'(DEPTH / 2) - {1'b0, half});
        else
            q = half;
        mag = $signed({1'b0, qtab[q]});
    end

    always_ff @(posedge clk)
    begin
        sine_value_reg <= neg ? -mag : mag;
    end

    assign sine_value = sine_value_reg;

endmodule

`default_nettype wire

// File: design/stereo_fuzz_wah_effect_unit.sv
// ------------------------------------------------------------------
// Stereo fuzz and swept wah effect unit
// Each stereo pair is optionally clipped on a stepped grid and then
// optionally passed through a two-pole resonator whose centre is swept
// by a sine LFO. One pair is processed at a time: in_stall is high from
// the transfer of a pair until its result is written to the output
// register. Fuzz tests one grid threshold at a time, from the top down,
// until both samples are clipped or the threshold reaches zero. The wah
// is computed with one shared 20 by 20 multiplier, an 18-step divider
// and a 17-step square root. The result load waits while out_stall
// holds the previous result in the output register. A new pair is taken
// while a finished result still waits in the output register.
// ------------------------------------------------------------------
`default_nettype none
`include "stereo_fuzz_wah_effect_unit_defines.svh"

module stereo_fuzz_wah_effect_unit #(
    parameter int SINE_TABLE_DEPTH = sfw_pkg::SINE_TABLE_DEPTH,
    parameter int LFO_PHASE_BITS   = sfw_pkg::LFO_PHASE_BITS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  signed [sfw_pkg::SAMPLE_W-1:0] left_sample,
    input  wire  signed [sfw_pkg::SAMPLE_W-1:0] right_sample,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [sfw_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sfw_pkg::SAMPLE_W-1:0] right_out,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [sfw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [sfw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FUZZ   = 5'd1;
    localparam logic [4:0] S_LFO    = 5'd2;
    localparam logic [4:0] S_MOD    = 5'd3;
    localparam logic [4:0] S_FREQ   = 5'd4;
    localparam logic [4:0] S_FQM    = 5'd5;
    localparam logic [4:0] S_COS    = 5'd6;
    localparam logic [4:0] S_NUM    = 5'd7;
    localparam logic [4:0] S_DIVSET = 5'd8;
    localparam logic [4:0] S_DIV    = 5'd9;
    localparam logic [4:0] S_CTFIX  = 5'd10;
    localparam logic [4:0] S_CTSQ   = 5'd11;
    localparam logic [4:0] S_B1     = 5'd12;
    localparam logic [4:0] S_B1S    = 5'd13;
    localparam logic [4:0] S_SQRT   = 5'd14;
    localparam logic [4:0] S_AMP    = 5'd15;
    localparam logic [4:0] S_AMPS   = 5'd16;
    localparam logic [4:0] S_L0     = 5'd17;
    localparam logic [4:0] S_L1     = 5'd18;
    localparam logic [4:0] S_L2     = 5'd19;
    localparam logic [4:0] S_L3     = 5'd20;
    localparam logic [4:0] S_R1     = 5'd21;
    localparam logic [4:0] S_R2     = 5'd22;
    localparam logic [4:0] S_R3     = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    function automatic logic signed [39:0] round16(input logic signed [39:0] v);
        return (v + 40'sd32768) >>> 16;
    endfunction

    function automatic logic signed [39:0] trunc16(input logic signed [39:0] v);
        return (v + ((v < 0) ? 40'sd65535 : 40'sd0)) >>> 16;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'(sfw_pkg::OUT_MAX))
            return 16'(sfw_pkg::OUT_MAX);
        else if (v < -40'(sfw_pkg::OUT_MAX))
            return -16'(sfw_pkg::OUT_MAX);
        else
            return v[15:0];
    endfunction

    logic [4:0]  state_reg;
    logic [4:0]  state_next;

    logic        fuzz_en_reg;
    logic        wah_en_reg;
    logic [5:0]  scale_reg;
    logic [14:0] cf_reg;
    logic [15:0] bw_reg;
    logic [15:0] pstep_reg;

    logic signed [15:0] pl0_reg;
    logic signed [15:0] pl1_reg;
    logic signed [15:0] pr0_reg;
    logic signed [15:0] pr1_reg;
    logic [LFO_PHASE_BITS-1:0] phase_reg;

    logic        out_valid_reg;
    logic signed [15:0] left_out_reg;
    logic signed [15:0] right_out_reg;

    logic signed [16:0] xl_reg;
    logic signed [16:0] xr_reg;
    logic signed [16:0] thr_reg;
    logic        dl_reg;
    logic        dr_reg;

    logic signed [39:0] prod_reg;
    logic [17:0] mod_reg;
    logic [16:0] r2_reg;
    logic [17:0] amp0_reg;
    logic signed [18:0] amp_reg;
    logic signed [18:0] b1_reg;
    logic signed [17:0] ct_reg;
    logic        neg_reg;
    logic [17:0] den_reg;
    logic [16:0] rem_reg;
    logic [17:0] dq_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] sq_v_reg;
    logic [33:0] sq_res_reg;
    logic [33:0] sq_bit_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] res_l_reg;
    logic signed [15:0] res_r_reg;

    logic signed [17:0] sine_value;
    logic [AW-1:0]      rom_addr;
    logic signed [19:0] op_a;
    logic signed [19:0] op_b;
    logic signed [39:0] op_a_ext;
    logic signed [39:0] op_b_ext;
    logic [16:0]        rq;
    logic [16:0]        one_minus_r2;
    logic [5:0]         scale_eff;
    logic signed [16:0] fuzz_step;
    logic               fuzz_end;
    logic               out_free;
    logic signed [39:0] prod_rnd;
    logic signed [40:0] num;
    logic [40:0]        num_mag;
    logic [17:0]        den_sum;
    logic [34:0]        div_n;
    logic [17:0]        div_t;
    logic [33:0]        sq_sum;
    logic [16:0]        ct_mag;
    logic signed [15:0] final_l;
    logic signed [15:0] final_r;

    sfw_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk        (clk),
        .addr       (rom_addr),
        .sine_value (sine_value)
    );

    assign rq           = 17'(sfw_pkg::ONE_Q16 - int'(bw_reg));
    assign one_minus_r2 = 17'(sfw_pkg::ONE_Q16 - int'(r2_reg));
    assign scale_eff    = (scale_reg == 6'd0) ? 6'd1 : scale_reg;
    assign fuzz_step    = 17'(scale_eff) * 17'(sfw_pkg::FUZZ_STEP_UNIT);
    assign fuzz_end     = (thr_reg <= 17'sd0) || (dl_reg && dr_reg);
    assign out_free     = !out_valid_reg || !out_stall;
    assign prod_rnd     = round16(prod_reg);
    assign num          = 41'(prod_reg) <<< 1;
    assign num_mag      = (num < 0) ? 41'(-num) : 41'(num);
    assign den_sum      = 18'(sfw_pkg::ONE_Q16) + 18'(r2_reg);
    assign div_n        = 35'(num_mag[33:0]) + 35'(den_sum >> 1);
    assign div_t        = {rem_reg, dq_reg[17]};
    assign sq_sum       = sq_res_reg + sq_bit_reg;
    assign ct_mag       = (dq_reg > 18'(sfw_pkg::ONE_Q16)) ? 17'(sfw_pkg::ONE_Q16)
                                                           : dq_reg[16:0];
    assign final_l      = wah_en_reg ? res_l_reg : sat16(40'(xl_reg));
    assign final_r      = wah_en_reg ? res_r_reg : sat16(40'(xr_reg));

    always_comb
    begin
        if (state_reg == S_COS)
            rom_addr = prod_rnd[15 -: AW] + AW'(SINE_TABLE_DEPTH / 4);
        else
            rom_addr = phase_reg[LFO_PHASE_BITS-1 -: AW];
    end

    always_comb
    begin
        op_a = 20'sd0;
        op_b = 20'sd0;
        unique case (state_reg)
            S_MOD:
            begin
                op_a = 20'(sfw_pkg::DEPTH_Q16);
                op_b = 20'(sine_value);
            end
            S_FREQ:
            begin
                op_a = 20'(rq);
                op_b = 20'(rq);
            end
            S_FQM:
            begin
                op_a = 20'(cf_reg);
                op_b = 20'(mod_reg);
            end
            S_COS:
            begin
                op_a = 20'(sfw_pkg::GAIN_Q16);
                op_b = 20'(one_minus_r2);
            end
            S_NUM:
            begin
                op_a = 20'(rq);
                op_b = 20'(sine_value);
            end
            S_CTSQ:
            begin
                op_a = 20'(ct_reg);
                op_b = 20'(ct_reg);
            end
            S_B1:
            begin
                op_a = 20'(rq);
                op_b = 20'(ct_reg);
            end
            S_AMP:
            begin
                op_a = 20'(amp0_reg);
                op_b = 20'(sq_res_reg[16:0]);
            end
            S_L0:
            begin
                op_a = 20'(amp_reg);
                op_b = 20'(xl_reg);
            end
            S_L1:
            begin
                op_a = 20'(b1_reg);
                op_b = 20'(pl0_reg);
            end
            S_L2:
            begin
                op_a = 20'(r2_reg);
                op_b = 20'(pl1_reg);
            end
            S_L3:
            begin
                op_a = 20'(amp_reg);
                op_b = 20'(xr_reg);
            end
            S_R1:
            begin
                op_a = 20'(b1_reg);
                op_b = 20'(pr0_reg);
            end
            S_R2:
            begin
                op_a = 20'(r2_reg);
                op_b = 20'(pr1_reg);
            end
            default:
            begin
                op_a = 20'sd0;
                op_b = 20'sd0;
            end
        endcase
        op_a_ext = 40'(op_a);
        op_b_ext = 40'(op_b);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = fuzz_en_reg ? S_FUZZ : (wah_en_reg ? S_LFO : S_OUT);
            S_FUZZ:
                if (fuzz_end)
                    state_next = wah_en_reg ? S_LFO : S_OUT;
            S_LFO:    state_next = S_MOD;
            S_MOD:    state_next = S_FREQ;
            S_FREQ:   state_next = S_FQM;
            S_FQM:    state_next = S_COS;
            S_COS:    state_next = S_NUM;
            S_NUM:    state_next = S_DIVSET;
            S_DIVSET: state_next = S_DIV;
            S_DIV:
                if (cnt_reg == 5'd0)
                    state_next = S_CTFIX;
            S_CTFIX:  state_next = S_CTSQ;
            S_CTSQ:   state_next = S_B1;
            S_B1:     state_next = S_B1S;
            S_B1S:    state_next = S_SQRT;
            S_SQRT:
                if (cnt_reg == 5'd0)
                    state_next = S_AMP;
            S_AMP:    state_next = S_AMPS;
            S_AMPS:   state_next = S_L0;
            S_L0:     state_next = S_L1;
            S_L1:     state_next = S_L2;
            S_L2:     state_next = S_L3;
            S_L3:     state_next = S_R1;
            S_R1:     state_next = S_R2;
            S_R2:     state_next = S_R3;
            S_R3:     state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a_ext * op_b_ext;
        unique case (state_reg)
            S_IDLE:
            begin
                xl_reg  <= 17'(left_sample);
                xr_reg  <= 17'(right_sample);
                thr_reg <= 17'(sfw_pkg::FUZZ_TOP);
                dl_reg  <= 1'b0;
                dr_reg  <= 1'b0;
            end
            S_FUZZ:
                if (!fuzz_end)
                begin
                    if (!dl_reg)
                    begin
                        if (xl_reg > thr_reg)
                        begin
                            xl_reg <= thr_reg;
                            dl_reg <= 1'b1;
                        end
                        else if (xl_reg < -thr_reg)
                        begin
                            xl_reg <= -thr_reg;
                            dl_reg <= 1'b1;
                        end
                    end
                    if (!dr_reg)
                    begin
                        if (xr_reg > thr_reg)
                        begin
                            xr_reg <= thr_reg;
                            dr_reg <= 1'b1;
                        end
                        else if (xr_reg < -thr_reg)
                        begin
                            xr_reg <= -thr_reg;
                            dr_reg <= 1'b1;
                        end
                    end
                    thr_reg <= thr_reg - fuzz_step;
                end
            S_FREQ:   mod_reg  <= 18'(40'(sfw_pkg::ONE_Q16) + prod_rnd);
            S_FQM:    r2_reg   <= prod_rnd[16:0];
            S_NUM:    amp0_reg <= prod_rnd[17:0];
            S_DIVSET:
            begin
                neg_reg <= num < 0;
                den_reg <= den_sum;
                cnt_reg <= 5'd17;
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (div_t >= den_reg)
                begin
                    rem_reg <= 17'(div_t - den_reg);
                    dq_reg  <= {dq_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t[16:0];
                    dq_reg  <= {dq_reg[16:0], 1'b0};
                end
            end
            S_CTFIX:  ct_reg <= neg_reg ? -18'(ct_mag) : 18'(ct_mag);
            S_B1:
            begin
                sq_v_reg   <= (34'd1 << 32) - prod_reg[33:0];
                sq_res_reg <= 34'd0;
                sq_bit_reg <= 34'd1 << 32;
                cnt_reg    <= 5'd16;
            end
            S_B1S:    b1_reg <= 19'((prod_reg + 40'sd16384) >>> 15);
            S_SQRT:
            begin
                cnt_reg    <= cnt_reg - 5'd1;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg   <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
            end
            S_AMPS:   amp_reg <= prod_rnd[18:0];
            S_L1:     acc_reg <= prod_reg;
            S_L2:     acc_reg <= acc_reg + prod_reg;
            S_L3:     res_l_reg <= sat16(trunc16(acc_reg - prod_reg));
            S_R1:     acc_reg <= prod_reg;
            S_R2:     acc_reg <= acc_reg + prod_reg;
            S_R3:     res_r_reg <= sat16(trunc16(acc_reg - prod_reg));
            default:
            begin
            end
        endcase
        if (state_reg == S_NUM)
        begin
            rem_reg <= 17'd0;
        end
        if (state_reg == S_DIVSET)
        begin
            rem_reg <= div_n[34:18];
            dq_reg  <= div_n[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fuzz_en_reg   <= 1'b0;
            wah_en_reg    <= 1'b0;
            scale_reg     <= 6'(sfw_pkg::FUZZ_SCALE_RESET);
            cf_reg        <= 15'd0;
            bw_reg        <= 16'd0;
            pstep_reg     <= 16'(sfw_pkg::LFO_STEP_RESET);
            pl0_reg       <= 16'sd0;
            pl1_reg       <= 16'sd0;
            pr0_reg       <= 16'sd0;
            pr1_reg       <= 16'sd0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sfw_pkg::REG_FUZZ_ENABLE:     fuzz_en_reg <= cfg_data[0];
                    sfw_pkg::REG_WAH_ENABLE:      wah_en_reg  <= cfg_data[0];
                    sfw_pkg::REG_FUZZ_SCALE:      scale_reg   <= cfg_data[5:0];
                    sfw_pkg::REG_WAH_CENTER_FREQ: cf_reg      <= cfg_data[14:0];
                    sfw_pkg::REG_WAH_BANDWIDTH:   bw_reg      <= cfg_data;
                    sfw_pkg::REG_LFO_PHASE_STEP:  pstep_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                pl1_reg       <= pl0_reg;
                pl0_reg       <= final_l;
                pr1_reg       <= pr0_reg;
                pr0_reg       <= final_r;
                phase_reg     <= phase_reg + LFO_PHASE_BITS'(pstep_reg);
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            left_out_reg  <= final_l;
            right_out_reg <= final_r;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    `SFW_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    `SFW_ASSERT_NEXT(a_result_load, state_reg == S_OUT && out_free,
                     out_valid_reg && state_reg == S_IDLE)
    `SFW_ASSERT_SAME(a_ct_range, state_reg == S_CTSQ,
                     ct_reg <= 18'sd65536 && ct_reg >= -18'sd65536)
    `SFW_ASSERT_SAME(a_sqrt_range, state_reg == S_AMP, sq_res_reg <= 34'd65536)

endmodule

`default_nettype wire

// File: tb/stereo_fuzz_wah_checker.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// Result checker for the stereo fuzz and wah effect unit
// Watches the configuration, input and output channels, predicts each
// processed pair from its own copy of the registers and filter state,
// and compares every output transfer with the oldest prediction.
// ------------------------------------------------------------------
`default_nettype none

module stereo_fuzz_wah_checker
    import sfw_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire                        in_stall,
    input  wire signed [SAMPLE_W-1:0]  left_sample,
    input  wire signed [SAMPLE_W-1:0]  right_sample,
    input  wire                        out_valid,
    input  wire                        out_stall,
    input  wire signed [SAMPLE_W-1:0]  left_out,
    input  wire signed [SAMPLE_W-1:0]  right_out,
    input  wire                        cfg_valid,
    input  wire                        cfg_ready,
    input  wire [CFG_INDEX_W-1:0]      cfg_index,
    input  wire [CFG_DATA_W-1:0]       cfg_data,
    output int                         fail_count,
    output int                         pairs_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_pair_t;

    logic                      fuzz_on;
    logic                      wah_on;
    logic [5:0]                clip_scale;
    logic [14:0]               centre_freq;
    logic [15:0]               bandwidth;
    logic [15:0]               phase_step;
    logic [LFO_PHASE_BITS-1:0] lfo_acc;
    longint                    hist_left [2];
    longint                    hist_right [2];
    stereo_pair_t              expected_pairs [$];

    function automatic longint sine_at(input longint unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          mag;
        logic            negative;
        negative = 1'b0;
        k = k % SINE_TABLE_DEPTH;
        if (k >= SINE_TABLE_DEPTH / 2)
        begin
            negative = 1'b1;
            k = k - SINE_TABLE_DEPTH / 2;
        end
        if (k > SINE_TABLE_DEPTH / 4)
            k = SINE_TABLE_DEPTH / 2 - k;
        x = (PI_Q30 * 2 * k) / SINE_TABLE_DEPTH;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 8192) >>> 14;
        if (mag > ONE_Q16)
            mag = ONE_Q16;
        return negative ? -mag : mag;
    endfunction

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint saturate(input longint v);
        if (v > OUT_MAX)
            return OUT_MAX;
        if (v < -OUT_MAX)
            return -OUT_MAX;
        return v;
    endfunction

    function automatic longint clip_to_grid(input longint x, input logic [5:0] scale);
        longint step;
        step = (scale == 0 ? 1 : scale) * FUZZ_STEP_UNIT;
        for (longint t = FUZZ_TOP; t > 0; t = t - step)
        begin
            if (x > t)
                return t;
            if (x < -t)
                return -t;
        end
        return x;
    endfunction

    function automatic longint shift_toward_zero(input longint v);
        return v < 0 ? -((-v) >>> 16) : v >>> 16;
    endfunction

    task automatic process_pair(input logic signed [SAMPLE_W-1:0] l_in,
                                input logic signed [SAMPLE_W-1:0] r_in);
        longint       l;
        longint       r;
        longint       s;
        longint       modv;
        longint       f;
        longint       c;
        longint       rq;
        longint       r2;
        longint       num;
        longint       den;
        longint       ct;
        longint       b1;
        longint       amp;
        stereo_pair_t res;
        l = l_in;
        r = r_in;
        if (fuzz_on)
        begin
            l = clip_to_grid(l, clip_scale);
            r = clip_to_grid(r, clip_scale);
        end
        if (wah_on)
        begin
            s = sine_at((longint'(lfo_acc) * SINE_TABLE_DEPTH) >> LFO_PHASE_BITS);
            modv = ONE_Q16 + round_q16(DEPTH_Q16 * s);
            f = round_q16(longint'(centre_freq) * modv) & 64'hFFFF;
            c = sine_at(((f * SINE_TABLE_DEPTH) >> 16) + SINE_TABLE_DEPTH / 4);
            rq = ONE_Q16 - longint'(bandwidth);
            r2 = round_q16(rq * rq);
            num = 2 * rq * c;
            den = ONE_Q16 + r2;
            ct = ((num < 0 ? -num : num) + den / 2) / den;
            if (ct > ONE_Q16)
                ct = ONE_Q16;
            if (num < 0)
                ct = -ct;
            b1 = round_q16(2 * rq * ct);
            amp = round_q16(GAIN_Q16 * (ONE_Q16 - r2));
            amp = round_q16(amp * int_sqrt((64'd1 << 32) - longint'(ct * ct)));
            l = saturate(shift_toward_zero(amp * l + b1 * hist_left[0] - r2 * hist_left[1]));
            r = saturate(shift_toward_zero(amp * r + b1 * hist_right[0] - r2 * hist_right[1]));
        end
        l = saturate(l);
        r = saturate(r);
        hist_left[1] = hist_left[0];
        hist_left[0] = l;
        hist_right[1] = hist_right[0];
        hist_right[0] = r;
        res.left = l[SAMPLE_W-1:0];
        res.right = r[SAMPLE_W-1:0];
        expected_pairs.insert(expected_pairs.size(), res);
        lfo_acc = lfo_acc + phase_step;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fuzz_on = 1'b0;
            wah_on = 1'b0;
            clip_scale = 6'(FUZZ_SCALE_RESET);
            centre_freq = '0;
            bandwidth = '0;
            phase_step = 16'(LFO_STEP_RESET);
            lfo_acc = '0;
            hist_left = '{0, 0};
            hist_right = '{0, 0};
            expected_pairs.delete();
            fail_count = 0;
            pairs_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FUZZ_ENABLE:     fuzz_on = cfg_data[0];
                    REG_WAH_ENABLE:      wah_on = cfg_data[0];
                    REG_FUZZ_SCALE:      clip_scale = cfg_data[5:0];
                    REG_WAH_CENTER_FREQ: centre_freq = cfg_data[14:0];
                    REG_WAH_BANDWIDTH:   bandwidth = cfg_data;
                    REG_LFO_PHASE_STEP:  phase_step = cfg_data;
                    default:             ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("output transfer with no pair outstanding");
                    fail_count++;
                end
                else
                begin
                    if (left_out !== expected_pairs[0].left)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               expected_pairs[0].left, left_out);
                        fail_count++;
                    end
                    if (right_out !== expected_pairs[0].right)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               expected_pairs[0].right, right_out);
                        fail_count++;
                    end
                    void'(expected_pairs.pop_front());
                end
            end
            if (in_valid && !in_stall)
                process_pair(left_sample, right_sample);
            pairs_pending = expected_pairs.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_stereo_fuzz_wah_effect_unit.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// Testbench for the stereo fuzz and wah effect unit
// Runs directed pairs at the sample extremes and clip thresholds under
// several register settings, then random settings with mostly random
// samples, with bursty input, a patterned output stall and one long
// output hold-off. The checker module predicts and compares.
// ------------------------------------------------------------------
`default_nettype none

module tb_stereo_fuzz_wah_effect_unit;
    import sfw_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    int                         fail_count;
    int                         pairs_pending;
    int                         burst_left;
    logic                       hold_request;
    int                         stall_mode;

    stereo_fuzz_wah_effect_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    stereo_fuzz_wah_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pairs_pending (pairs_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int hold_cycles;
        out_stall = 1'b0;
        stall_mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_cycles = 400;
                while (hold_cycles > 0)
                begin
                    out_stall = 1'b1;
                    @(negedge clk);
                    hold_cycles--;
                end
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 99) == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 1) == 0);
                default: out_stall = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        logic ready_seen;
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do
        begin
            ready_seen = cfg_ready;
            @(posedge clk);
            @(negedge clk);
        end
        while (!ready_seen);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_block();
        while (pairs_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        logic stall_seen;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid = 1'b1;
        left_sample = l;
        right_sample = r;
        do
        begin
            stall_seen = in_stall;
            @(posedge clk);
            @(negedge clk);
        end
        while (stall_seen);
        burst_left--;
    endtask

    task automatic end_phase();
        in_valid = 1'b0;
        burst_left = 0;
        drain_block();
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(FUZZ_TOP + $urandom_range(0, 2000) - 1000);
            3:       return 16'(-FUZZ_TOP - $urandom_range(0, 2000) + 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [SAMPLE_W-1:0] edge_values [12];
        edge_values = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd32000, 16'sd32001,
                        -16'sd32001, -16'sd32000, 16'sd1000, 16'sd999, -16'sd12345, 16'sh5555};
        rst_n = 1'b0;
        in_valid = 1'b0;
        left_sample = '0;
        right_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        hold_request = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 6; i++)
            send_pair(edge_values[i], edge_values[11 - i]);
        end_phase();

        write_register(REG_FUZZ_ENABLE, 16'hFFFF);
        write_register(REG_FUZZ_SCALE, 16'd0);
        for (int i = 0; i < 6; i++)
            send_pair(edge_values[i + 6], edge_values[i]);
        end_phase();
        write_register(REG_FUZZ_SCALE, 16'hFFFF);
        send_pair(16'sd32001, -16'sd32768);
        send_pair(16'sd31999, -16'sd5);
        end_phase();
        write_register(REG_FUZZ_SCALE, 16'd32);
        send_pair(16'sd31999, -16'sd999);
        end_phase();

        write_register(REG_WAH_ENABLE, 16'd1);
        write_register(REG_WAH_CENTER_FREQ, 16'hFFFF);
        write_register(REG_WAH_BANDWIDTH, 16'hFFFF);
        write_register(REG_LFO_PHASE_STEP, 16'd0);
        write_register(3'd6, 16'h1234);
        write_register(3'd7, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_pair(edge_values[i], edge_values[i + 4]);
        end_phase();
        write_register(REG_FUZZ_ENABLE, 16'd0);
        write_register(REG_WAH_CENTER_FREQ, 16'd0);
        write_register(REG_WAH_BANDWIDTH, 16'd0);
        write_register(REG_LFO_PHASE_STEP, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_pair(edge_values[i + 8], edge_values[i]);
        end_phase();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_register(REG_FUZZ_ENABLE, 16'($urandom));
            write_register(REG_WAH_ENABLE, 16'($urandom_range(0, 3) != 0));
            write_register(REG_FUZZ_SCALE, 16'($urandom_range(0, 63)));
            write_register(REG_WAH_CENTER_FREQ, 16'($urandom));
            write_register(REG_WAH_BANDWIDTH,
                           $urandom_range(0, 1) ? 16'($urandom_range(200, 8000)) : 16'($urandom));
            write_register(REG_LFO_PHASE_STEP, 16'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_register(3'($urandom_range(6, 7)), 16'($urandom));
            for (int i = 0; i < 75; i++)
            begin
                if (ph == 4 && i == 20)
                    hold_request = 1'b1;
                send_pair(random_sample(), random_sample());
            end
            end_phase();
        end

        while (pairs_pending != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
